// File: rtl/cfir_pkg.sv
`default_nettype none

package cfir_pkg;

  localparam int MAX_TAPS = 64;
  localparam int AW       = $clog2(MAX_TAPS);
  localparam int SW       = 16;
  localparam int CW       = 16;
  localparam int TCW      = 7;
  localparam int CMDW     = 2;
  localparam int PROD_W   = SW + CW;
  localparam int ACC_W    = PROD_W + AW + 2;

  typedef enum logic [CMDW-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/cfir_mac.sv
`default_nettype none

module cfir_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfir_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [cfir_pkg::CW-1:0]    c_re,
  input  logic signed [cfir_pkg::CW-1:0]    c_im,
  input  logic signed [cfir_pkg::SW-1:0]    x_re,
  input  logic signed [cfir_pkg::SW-1:0]    x_im,
  output logic signed [cfir_pkg::SW-1:0]    res_re,
  output logic signed [cfir_pkg::SW-1:0]    res_im,
  output logic                              res_sat,
  output logic                              done
);

  localparam int ACC_W = cfir_pkg::ACC_W;
  localparam int PW    = cfir_pkg::PROD_W;
  localparam int SW    = cfir_pkg::SW;
  localparam int CW    = cfir_pkg::CW;
  localparam int QW    = ACC_W - (CW - 1);
  localparam int RND   = (2 ** (CW - 1)) - 1;
  localparam logic signed [QW-1:0] QMAX = QW'((2 ** (SW - 1)) - 1);
  localparam logic signed [QW-1:0] QMIN = QW'(-(2 ** (SW - 1)));

  logic signed [PW-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                    p_vld_r, p_last_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic                    done_r;
  logic [SW:0]             sc_re, sc_im;

  // divide by 2^(CW-1) toward zero, then clip; msb of result is the clip flag
  function automatic logic [SW:0] scale_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [QW-1:0]    q;
    t = a[ACC_W-1] ? (a + ACC_W'(RND)) : a;
    q = QW'(t >>> (CW - 1));
    if (q > QMAX) begin
      scale_sat = {1'b1, QMAX[SW-1:0]};
    end else if (q < QMIN) begin
      scale_sat = {1'b1, QMIN[SW-1:0]};
    end else begin
      scale_sat = {1'b0, q[SW-1:0]};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl_i.vld) begin
      p_rr_r <= c_re * x_re;
      p_ii_r <= c_im * x_im;
      p_ri_r <= c_re * x_im;
      p_ir_r <= c_im * x_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (p_vld_r) begin
      acc_re_r <= acc_re_r + ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
      acc_im_r <= acc_im_r + ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r  <= 1'b0;
      p_last_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      p_vld_r  <= ctrl_i.vld;
      p_last_r <= ctrl_i.vld && ctrl_i.last;
      if (ctrl_i.clr) begin
        done_r <= 1'b0;
      end else if (p_vld_r && p_last_r) begin
        done_r <= 1'b1;
      end
    end
  end

  assign sc_re   = scale_sat(acc_re_r);
  assign sc_im   = scale_sat(acc_im_r);
  assign res_re  = sc_re[SW-1:0];
  assign res_im  = sc_im[SW-1:0];
  assign res_sat = sc_re[SW] | sc_im[SW];
  assign done    = done_r;

endmodule

`default_nettype wire

// File: rtl/complex_fir_filter_unit.sv
`default_nettype none

// Channel   Direction  Ports                                        Transfer
// in        input      in_command, in_sample_re/im, in_coef_index,  in_valid & in_ready
//                      in_coef_re/im
// out       output     out_re, out_im, out_saturated                out_valid & out_ready
// cfg       input      cfg_wr_data (tap_count)                      cfg_wr_en
//
// Sample: one tap per cycle through the coefficient and history RAM read ports,
// at least one read even with tap_count zero; the result is loaded once the output
// register is free, when in_ready returns; other commands leave in_ready high.
// Reset (sync, rst_n low) clears the per-entry valid bits, so both RAMs read as zero.
// History clear drops every history entry. A result waits in the output register; a new
// item is taken meanwhile, but the next sample result waits for out_ready.

module complex_fir_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cfir_pkg::CMDW-1:0]         in_command,
  input  logic signed [cfir_pkg::SW-1:0]    in_sample_re,
  input  logic signed [cfir_pkg::SW-1:0]    in_sample_im,
  input  logic [cfir_pkg::AW-1:0]           in_coef_index,
  input  logic signed [cfir_pkg::CW-1:0]    in_coef_re,
  input  logic signed [cfir_pkg::CW-1:0]    in_coef_im,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cfir_pkg::SW-1:0]    out_re,
  output logic signed [cfir_pkg::SW-1:0]    out_im,
  output logic                              out_saturated,
  input  logic                              cfg_wr_en,
  input  logic [cfir_pkg::TCW-1:0]          cfg_wr_data
);

  localparam int N   = cfir_pkg::MAX_TAPS;
  localparam int AW  = cfir_pkg::AW;
  localparam int SW  = cfir_pkg::SW;
  localparam int CW  = cfir_pkg::CW;
  localparam int TCW = cfir_pkg::TCW;
  localparam logic [TCW-1:0] TAPS_MAX = TCW'(N);

  cfir_pkg::state_t    state_r, state_nxt;
  cfir_pkg::cmd_t      cmd;
  cfir_pkg::mac_ctrl_t mac_ctrl;

  logic [TCW-1:0] tap_count_r;
  logic [TCW-1:0] taps_eff;
  logic [TCW-1:0] taps_m1;
  logic [AW-1:0]  ptr_r, base_r, k_r, last_r;
  logic           kill_r;
  logic [AW-1:0]  hist_addr;

  logic [2*CW-1:0] coef_mem [N];
  logic [2*SW-1:0] hist_mem [N];
  logic [N-1:0]    coef_vld_r, hist_vld_r;

  logic [2*CW-1:0] coef_q_r;
  logic [2*SW-1:0] hist_q_r;
  logic            coef_vq_r, hist_vq_r, kill_q_r;
  logic            rd_vld_r, rd_last_r;

  logic [2*CW-1:0] c_sel;
  logic [2*SW-1:0] x_sel;

  logic accept, do_sample, do_coef, do_clear;
  logic rd_en, rd_last, out_free, load_out;

  logic signed [SW-1:0] res_re, res_im;
  logic                 res_sat, mac_done;

  logic                 out_valid_r;
  logic signed [SW-1:0] out_re_r, out_im_r;
  logic                 out_sat_r;

  assign cmd       = cfir_pkg::cmd_t'(in_command);
  assign accept    = in_valid && in_ready;
  assign hist_addr = base_r - k_r;
  assign out_free  = !out_valid_r || out_ready;
  assign rd_last   = (k_r == last_r);
  assign taps_eff  = (tap_count_r > TAPS_MAX) ? TAPS_MAX : tap_count_r;
  assign taps_m1   = taps_eff - TCW'(1);

  always_comb begin
    do_sample = 1'b0;
    do_coef   = 1'b0;
    do_clear  = 1'b0;
    unique case (cmd)
      cfir_pkg::CMD_SAMPLE: do_sample = accept;
      cfir_pkg::CMD_COEF:   do_coef   = accept;
      cfir_pkg::CMD_CLEAR:  do_clear  = accept;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfir_pkg::ST_IDLE: if (do_sample) state_nxt = cfir_pkg::ST_RUN;
      cfir_pkg::ST_RUN:  if (rd_last) state_nxt = cfir_pkg::ST_WAIT;
      cfir_pkg::ST_WAIT: if (mac_done && out_free) state_nxt = cfir_pkg::ST_IDLE;
      default:           state_nxt = cfir_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      cfir_pkg::ST_IDLE: in_ready = 1'b1;
      cfir_pkg::ST_RUN:  rd_en    = 1'b1;
      cfir_pkg::ST_WAIT: load_out = mac_done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfir_pkg::ST_IDLE;
      tap_count_r <= TAPS_MAX;
      ptr_r       <= '0;
      base_r      <= '0;
      k_r         <= '0;
      last_r      <= '0;
      kill_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      if (do_sample) begin
        base_r <= ptr_r;
        ptr_r  <= ptr_r + AW'(1);
        k_r    <= '0;
        kill_r <= (taps_eff == '0);
        last_r <= (taps_eff == '0) ? '0 : taps_m1[AW-1:0];
      end else begin
        if (do_clear) begin
          ptr_r <= '0;
        end
        if (rd_en) begin
          k_r <= k_r + AW'(1);
        end
      end
    end
  end

  // per-entry valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      hist_vld_r <= '0;
    end else begin
      if (do_coef) begin
        coef_vld_r[in_coef_index] <= 1'b1;
      end
      if (do_clear) begin
        hist_vld_r <= '0;
      end else if (do_sample) begin
        hist_vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_coef) begin
      coef_mem[in_coef_index] <= {in_coef_re, in_coef_im};
    end
    if (rd_en) begin
      coef_q_r <= coef_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (do_sample) begin
      hist_mem[ptr_r] <= {in_sample_re, in_sample_im};
    end
    if (rd_en) begin
      hist_q_r <= hist_mem[hist_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      coef_vq_r <= coef_vld_r[k_r];
      hist_vq_r <= hist_vld_r[hist_addr];
      kill_q_r  <= kill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_en;
      rd_last_r <= rd_en && rd_last;
    end
  end

  assign c_sel = coef_vq_r ? coef_q_r : '0;
  assign x_sel = (hist_vq_r && !kill_q_r) ? hist_q_r : '0;

  assign mac_ctrl.clr  = do_sample;
  assign mac_ctrl.vld  = rd_vld_r;
  assign mac_ctrl.last = rd_last_r;

  cfir_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (mac_ctrl),
    .c_re    (c_sel[2*CW-1:CW]),
    .c_im    (c_sel[CW-1:0]),
    .x_re    (x_sel[2*SW-1:SW]),
    .x_im    (x_sel[SW-1:0]),
    .res_re  (res_re),
    .res_im  (res_im),
    .res_sat (res_sat),
    .done    (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_re_r  <= res_re;
      out_im_r  <= res_im;
      out_sat_r <= res_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_re        = out_re_r;
  assign out_im        = out_im_r;
  assign out_saturated = out_sat_r;

  a_sample_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    do_sample |=> (state_r == cfir_pkg::ST_RUN))
    else $error("sample transfer did not start the tap loop");

  a_no_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfir_pkg::ST_RUN) |-> !mac_done)
    else $error("accumulator done while taps still being read");

  a_result_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == cfir_pkg::ST_WAIT))
    else $error("result appeared outside the wait state");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> ((hist_vld_r == '0) && (ptr_r == '0)))
    else $error("history clear left entries valid");

endmodule

`default_nettype wire

// File: dv/complex_fir_filter_unit_chk.sv
module complex_fir_filter_unit_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [cfir_pkg::CMDW-1:0]     in_command,
  input  logic signed [cfir_pkg::SW-1:0] in_sample_re,
  input  logic signed [cfir_pkg::SW-1:0] in_sample_im,
  input  logic [cfir_pkg::AW-1:0]       in_coef_index,
  input  logic signed [cfir_pkg::CW-1:0] in_coef_re,
  input  logic signed [cfir_pkg::CW-1:0] in_coef_im,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [cfir_pkg::SW-1:0] out_re,
  input  logic signed [cfir_pkg::SW-1:0] out_im,
  input  logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [cfir_pkg::TCW-1:0]      cfg_wr_data,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_TAPS = cfir_pkg::MAX_TAPS;
  localparam int     AW       = cfir_pkg::AW;
  localparam int     SW       = cfir_pkg::SW;
  localparam int     CW       = cfir_pkg::CW;
  localparam int     TCW      = cfir_pkg::TCW;
  localparam longint SAT_HI   = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) << (SW - 1));
  localparam longint Q_DIV    = longint'(1) << (CW - 1);

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 sat;
  } fir_out_t;

  logic signed [CW-1:0] tap_re [MAX_TAPS];
  logic signed [CW-1:0] tap_im [MAX_TAPS];
  logic signed [SW-1:0] hist_re [MAX_TAPS];
  logic signed [SW-1:0] hist_im [MAX_TAPS];
  logic [AW-1:0]        hist_wr_ptr;
  logic [TCW-1:0]       active_taps;
  fir_out_t             pending_outputs [$];
  int                   mismatches;

  function automatic logic signed [SW-1:0] clip_out(input longint v, inout logic clipped);
    if (v > SAT_HI) begin
      clipped = 1'b1;
      return SW'(SAT_HI);
    end
    if (v < SAT_LO) begin
      clipped = 1'b1;
      return SW'(SAT_LO);
    end
    return SW'(v);
  endfunction

  // pushes the sample into the history and returns the filtered output
  function automatic fir_out_t fir_response(input logic signed [SW-1:0] sr,
                                            input logic signed [SW-1:0] si);
    longint        acc_re;
    longint        acc_im;
    int            n;
    logic [AW-1:0] slot;
    fir_out_t      r;
    hist_re[hist_wr_ptr] = sr;
    hist_im[hist_wr_ptr] = si;
    n = (active_taps > MAX_TAPS) ? MAX_TAPS : int'(active_taps);
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < n; k++) begin
      slot = hist_wr_ptr - AW'(k);
      acc_re += longint'(tap_re[k]) * longint'(hist_re[slot])
              - longint'(tap_im[k]) * longint'(hist_im[slot]);
      acc_im += longint'(tap_re[k]) * longint'(hist_im[slot])
              + longint'(tap_im[k]) * longint'(hist_re[slot]);
    end
    hist_wr_ptr = hist_wr_ptr + AW'(1);
    r.sat = 1'b0;
    r.re  = clip_out(acc_re / Q_DIV, r.sat);
    r.im  = clip_out(acc_im / Q_DIV, r.sat);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fir_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        tap_re[k]  = '0;
        tap_im[k]  = '0;
        hist_re[k] = '0;
        hist_im[k] = '0;
      end
      hist_wr_ptr = '0;
      active_taps = TCW'(MAX_TAPS);
      pending_outputs.delete();
    end else begin
      // result side first so an output cannot match an item taken at the same edge
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected output: expected none, actual re=%0d im=%0d sat=%0d",
                   $time, out_re, out_im, out_saturated);
          mismatches++;
        end else begin
          want = pending_outputs.pop_front();
          check_field("out_re", want.re, out_re);
          check_field("out_im", want.im, out_im);
          check_field("out_saturated", want.sat, out_saturated);
        end
      end
      if (cfg_wr_en)
        active_taps = cfg_wr_data;
      if (in_valid && in_ready) begin
        case (cfir_pkg::cmd_t'(in_command))
          cfir_pkg::CMD_SAMPLE: begin
            want = fir_response(in_sample_re, in_sample_im);
            pending_outputs.insert(pending_outputs.size(), want);
          end
          cfir_pkg::CMD_COEF: begin
            tap_re[in_coef_index] = in_coef_re;
            tap_im[in_coef_index] = in_coef_im;
          end
          cfir_pkg::CMD_CLEAR: begin
            for (int k = 0; k < MAX_TAPS; k++) begin
              hist_re[k] = '0;
              hist_im[k] = '0;
            end
            hist_wr_ptr = '0;
          end
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_outputs.size();
  end

endmodule

// File: dv/complex_fir_filter_unit_tb.sv
module complex_fir_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TAPS     = cfir_pkg::MAX_TAPS;
  localparam int CMDW         = cfir_pkg::CMDW;
  localparam int AW           = cfir_pkg::AW;
  localparam int SW           = cfir_pkg::SW;
  localparam int CW           = cfir_pkg::CW;
  localparam int TCW          = cfir_pkg::TCW;
  localparam int N_PHASES     = 12;
  localparam int PHASE_ITEMS  = 95;
  localparam int SETTLE_CYC   = 80;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMDW-1:0]      in_command;
  logic signed [SW-1:0] in_sample_re;
  logic signed [SW-1:0] in_sample_im;
  logic [AW-1:0]        in_coef_index;
  logic signed [CW-1:0] in_coef_re;
  logic signed [CW-1:0] in_coef_im;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SW-1:0] out_re;
  logic signed [SW-1:0] out_im;
  logic                 out_saturated;
  logic                 cfg_wr_en;
  logic [TCW-1:0]       cfg_wr_data;
  int                   fail_count;
  int                   pending_count;
  logic                 idle_on;

  complex_fir_filter_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .in_coef_index(in_coef_index),
    .in_coef_re   (in_coef_re),
    .in_coef_im   (in_coef_im),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_re       (out_re),
    .out_im       (out_im),
    .out_saturated(out_saturated),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  complex_fir_filter_unit_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .in_coef_index(in_coef_index),
    .in_coef_re   (in_coef_re),
    .in_coef_im   (in_coef_im),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_re       (out_re),
    .out_im       (out_im),
    .out_saturated(out_saturated),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic signed [15:0] rand_word(input int shift);
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> shift;
  endfunction

  task automatic send_item(input cfir_pkg::cmd_t cmd, input logic signed [SW-1:0] sre,
                           input logic signed [SW-1:0] sim, input logic [AW-1:0] idx,
                           input logic signed [CW-1:0] cre, input logic signed [CW-1:0] cim);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_sample_re  <= sre;
    in_sample_im  <= sim;
    in_coef_index <= idx;
    in_coef_re    <= cre;
    in_coef_im    <= cim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int sample_shift, input int coef_shift);
    int unsigned    pick;
    int             s_shift;
    cfir_pkg::cmd_t cmd;
    pick    = $urandom_range(0, 99);
    s_shift = ($urandom_range(0, 3) == 0) ? 0 : sample_shift;
    if (pick < 82)      cmd = cfir_pkg::CMD_SAMPLE;
    else if (pick < 93) cmd = cfir_pkg::CMD_COEF;
    else if (pick < 97) cmd = cfir_pkg::CMD_CLEAR;
    else                cmd = cfir_pkg::CMD_RSVD;
    send_item(cmd, rand_word(s_shift), rand_word(s_shift), AW'($urandom),
              rand_word(coef_shift), rand_word(coef_shift));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // coefficient writes and clears leave no result, so let the block settle too
  task automatic write_tap_count(input logic [TCW-1:0] v);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned phase_taps [N_PHASES];
    int          eff_taps;
    int          n_writes;
    int          s_shift;
    int          c_shift;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = cfir_pkg::CMD_SAMPLE;
    in_sample_re  = '0;
    in_sample_im  = '0;
    in_coef_index = '0;
    in_coef_re    = '0;
    in_coef_im    = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    idle_on       = 1'b1;
    phase_taps    = '{127, 1, 64, 0, 3, 17, 2, 64, 0, 0, 0, 0};
    for (int p = 8; p < N_PHASES; p++)
      phase_taps[p] = $urandom_range(0, 127);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full-scale corners, clear, unused command, truncation
    send_item(cfir_pkg::CMD_SAMPLE, 16'sh7fff, -16'sh8000, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_COEF, 16'sh1234, -16'sh1234, 6'd0, -16'sh8000, 16'sh0);
    send_item(cfir_pkg::CMD_SAMPLE, -16'sh8000, 16'sh7fff, 6'd3, 16'sh7fff, 16'sh7fff);
    send_item(cfir_pkg::CMD_COEF, 16'sh0, 16'sh0, 6'd63, 16'sh7fff, -16'sh8000);
    send_item(cfir_pkg::CMD_SAMPLE, 16'sh7fff, -16'sh8000, 6'd63, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_RSVD, -16'sh1, -16'sh1, 6'd63, -16'sh1, -16'sh1);
    send_item(cfir_pkg::CMD_CLEAR, -16'sh8000, 16'sh7fff, 6'd42, 16'sh5555, -16'sh5556);
    send_item(cfir_pkg::CMD_SAMPLE, 16'sh1, -16'sh1, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_COEF, 16'sh0, 16'sh0, 6'd0, 16'sh1, -16'sh1);
    send_item(cfir_pkg::CMD_SAMPLE, -16'sh5, 16'sh7, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_SAMPLE, -16'sh8000, -16'sh8000, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_COEF, 16'sh0, 16'sh0, 6'd1, -16'sh1, 16'sh7fff);
    send_item(cfir_pkg::CMD_SAMPLE, 16'sh0, 16'sh0, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_COEF, 16'sh0, 16'sh0, 6'd2, -16'sh8000, -16'sh8000);
    send_item(cfir_pkg::CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_SAMPLE, -16'sh8000, -16'sh8000, 6'd0, 16'sh0, 16'sh0);
    write_tap_count(TCW'(0));
    send_item(cfir_pkg::CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 6'd0, 16'sh0, 16'sh0);
    send_item(cfir_pkg::CMD_SAMPLE, -16'sh8000, 16'sh0, 6'd0, 16'sh0, 16'sh0);

    for (int p = 0; p < N_PHASES; p++) begin
      write_tap_count(TCW'(phase_taps[p]));
      idle_on  = (p % 3 != 1);
      eff_taps = (phase_taps[p] > MAX_TAPS) ? MAX_TAPS : phase_taps[p];
      n_writes = (eff_taps > 24) ? 24 : eff_taps;
      c_shift  = $urandom_range(0, 12);
      s_shift  = $urandom_range(0, 8);
      for (int k = 0; k < n_writes; k++)
        send_item(cfir_pkg::CMD_COEF, rand_word(0), rand_word(0), AW'(k),
                  rand_word(c_shift), rand_word(c_shift));
      for (int i = n_writes; i < PHASE_ITEMS; i++)
        send_random(s_shift, c_shift);
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #16ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
